[rtl/lpg_pkg.sv]
// lpg_pkg: shared constants, controller state type and the command/status
// structs that join the line controller and the line datapath
// no dependencies
package lpg_pkg;

  localparam int COORD_W        = 6;
  localparam int COLOR_W        = 24;
  localparam int COORD_BITS_DEF = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;   // capture the segment endpoints and color
    logic setup;  // orient the segment and clear the error accumulator
    logic step;   // present the current pixel and advance along the major axis
  } cmd_t;

  typedef struct packed {
    logic at_end; // walk position equals the major end
  } status_t;

endpackage

[rtl/lpg_seg_if.sv]
// lpg_seg_if: segment channel (two endpoints and a color) with valid/ready
// depends on lpg_pkg
interface lpg_seg_if;
  logic                         valid;
  logic                         ready;
  logic [lpg_pkg::COORD_W-1:0]  start_x;
  logic [lpg_pkg::COORD_W-1:0]  start_y;
  logic [lpg_pkg::COORD_W-1:0]  end_x;
  logic [lpg_pkg::COORD_W-1:0]  end_y;
  logic [lpg_pkg::COLOR_W-1:0]  line_color;

  modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

[rtl/lpg_pix_if.sv]
// lpg_pix_if: pixel channel (coordinates, color, last flag) with valid/ready
// depends on lpg_pkg
interface lpg_pix_if;
  logic                         valid;
  logic                         ready;
  logic [lpg_pkg::COORD_W-1:0]  pixel_x;
  logic [lpg_pkg::COORD_W-1:0]  pixel_y;
  logic [lpg_pkg::COLOR_W-1:0]  pixel_color;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

[rtl/lpg_ctrl.sv]
// lpg_ctrl: line controller state machine, owns the input ready and the
// output valid flag; drives the datapath through lpg_pkg::cmd_t
module lpg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lpg_pkg::status_t status,
  output lpg_pkg::cmd_t    cmd
);

  lpg_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    cmd            = '0;
    // output register drains independently of the walk
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      lpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lpg_pkg::ST_SETUP;
        end
      end
      lpg_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = lpg_pkg::ST_WALK;
      end
      lpg_pkg::ST_WALK: begin
        if (!out_valid || out_ready) begin
          cmd.step       = 1'b1;
          out_valid_next = 1'b1;
          if (status.at_end) state_next = lpg_pkg::ST_IDLE;
        end
      end
      default: state_next = lpg_pkg::ST_IDLE;
    endcase
  end

  a_load_then_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == lpg_pkg::ST_SETUP)
    else $error("segment capture not followed by setup");

  a_setup_then_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.setup |=> state == lpg_pkg::ST_WALK && !cmd.load)
    else $error("setup not followed by walk");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    cmd.step && status.at_end |=> state == lpg_pkg::ST_IDLE && out_valid)
    else $error("last pixel did not end the line");

  a_stall_holds_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && !$past(cmd.step))
    else $error("pixel overwritten while stalled");

endmodule

[rtl/lpg_datapath.sv]
// lpg_datapath: segment registers, orientation logic, Bresenham walk and
// the output pixel register; controlled by lpg_ctrl through lpg_pkg types
module lpg_datapath #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  lpg_pkg::cmd_t               cmd,
  output lpg_pkg::status_t            status,
  input  logic [lpg_pkg::COORD_W-1:0] start_x,
  input  logic [lpg_pkg::COORD_W-1:0] start_y,
  input  logic [lpg_pkg::COORD_W-1:0] end_x,
  input  logic [lpg_pkg::COORD_W-1:0] end_y,
  input  logic [lpg_pkg::COLOR_W-1:0] line_color,
  output logic [lpg_pkg::COORD_W-1:0] pixel_x,
  output logic [lpg_pkg::COORD_W-1:0] pixel_y,
  output logic [lpg_pkg::COLOR_W-1:0] pixel_color,
  output logic                        last_pixel
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 3;  // accumulator stays within -span .. 3*span-1

  // captured segment
  logic [C-1:0]                ax, ay, bx, by;
  logic [lpg_pkg::COLOR_W-1:0] held_color;

  // walk state
  logic [C-1:0]        major_pos, major_end, minor_pos, span;
  logic [C:0]          twice_minor;
  logic signed [E-1:0] error_acc, error_acc_next;
  logic                minor_step_up, steep_flag;

  // setup terms
  logic [C-1:0] dx, dy, maj0, min0, maj1, min1;
  logic         steep, swap;

  // step terms
  logic signed [E-1:0] err_sum;
  logic                minor_move;

  always_comb begin
    dx    = (ax > bx) ? ax - bx : bx - ax;
    dy    = (ay > by) ? ay - by : by - ay;
    steep = dy > dx;
    maj0  = steep ? ay : ax;
    min0  = steep ? ax : ay;
    maj1  = steep ? by : bx;
    min1  = steep ? bx : by;
    swap  = maj0 > maj1;
  end

  always_comb begin
    err_sum    = error_acc + $signed({2'b00, twice_minor});
    minor_move = err_sum >= $signed({3'b000, span});
    error_acc_next = minor_move ? err_sum - $signed({2'b00, span, 1'b0}) : err_sum;
  end

  assign status.at_end = major_pos == major_end;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax         <= start_x[C-1:0];
      ay         <= start_y[C-1:0];
      bx         <= end_x[C-1:0];
      by         <= end_y[C-1:0];
      held_color <= line_color;
    end
    if (cmd.setup) begin
      steep_flag    <= steep;
      major_pos     <= swap ? maj1 : maj0;
      major_end     <= swap ? maj0 : maj1;
      minor_pos     <= swap ? min1 : min0;
      minor_step_up <= swap ? (min0 > min1) : (min1 > min0);
      span          <= steep ? dy : dx;
      twice_minor   <= {(steep ? dx : dy), 1'b0};
      error_acc     <= '0;
    end
    if (cmd.step) begin
      pixel_x     <= lpg_pkg::COORD_W'(steep_flag ? minor_pos : major_pos);
      pixel_y     <= lpg_pkg::COORD_W'(steep_flag ? major_pos : minor_pos);
      pixel_color <= held_color;
      last_pixel  <= status.at_end;
      if (!status.at_end) begin
        error_acc <= error_acc_next;
        major_pos <= major_pos + 1'b1;
        if (minor_move) minor_pos <= minor_step_up ? minor_pos + 1'b1 : minor_pos - 1'b1;
      end
    end
  end

endmodule

[rtl/line_pixel_generator_core.sv]
// line_pixel_generator_core: Bresenham line rasterizer top level
// depends on lpg_pkg, lpg_seg_if, lpg_pix_if, lpg_ctrl, lpg_datapath
//
// usage:
//   seg channel (sink): one line segment per beat, endpoints start/end and a
//   24-bit color; coordinates keep their low COORD_BITS bits.
//   pix channel (source): one beat per pixel along the major axis, from the
//   lower major coordinate upward, last_pixel set on the final beat.
//   order: the segment beat is captured, then oriented in setup, and the
//   walk then registers the first pixel; pixels follow one per cycle while
//   pix.ready is high, paced by the single-step walk of the error
//   accumulator. a line has N pixels (1 to 2^COORD_BITS); seg.ready is
//   high only between lines.
//   the last pixel sits in the output register while the next segment is
//   already taken in.
//   stall: when pix.ready is low the current pixel holds and the walk waits.
//   reset (rst, synchronous): returns to idle and drops pix.valid; a line in
//   progress is abandoned.
module line_pixel_generator_core #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lpg_seg_if.sink   seg,
  lpg_pix_if.source pix
);

  lpg_pkg::cmd_t    cmd;
  lpg_pkg::status_t status;

  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg.valid),
    .in_ready  (seg.ready),
    .out_valid (pix.valid),
    .out_ready (pix.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lpg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .start_x     (seg.start_x),
    .start_y     (seg.start_y),
    .end_x       (seg.end_x),
    .end_y       (seg.end_y),
    .line_color  (seg.line_color),
    .pixel_x     (pix.pixel_x),
    .pixel_y     (pix.pixel_y),
    .pixel_color (pix.pixel_color),
    .last_pixel  (pix.last_pixel)
  );

endmodule

[tb/sv/tb_line_pixel_generator_core.sv]
// tb_line_pixel_generator_core: self-checking bench for the Bresenham line rasterizer,
// a directed table of segments then random segments, every pixel beat checked in order
// depends on lpg_pkg, lpg_seg_if, lpg_pix_if, line_pixel_generator_core
module tb_line_pixel_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_LINES = 360;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PRINT_LIMIT  = 100;
  localparam int GRID_PIXELS  = 1 << lpg_pkg::COORD_BITS_DEF;

  typedef struct packed {
    logic [lpg_pkg::COORD_W-1:0] sx;
    logic [lpg_pkg::COORD_W-1:0] sy;
    logic [lpg_pkg::COORD_W-1:0] ex;
    logic [lpg_pkg::COORD_W-1:0] ey;
    logic [lpg_pkg::COLOR_W-1:0] color;
  } segment_t;

  typedef struct packed {
    logic [lpg_pkg::COORD_W-1:0] x;
    logic [lpg_pkg::COORD_W-1:0] y;
    logic [lpg_pkg::COLOR_W-1:0] color;
    logic                        last;
  } pixel_t;

  // typed rows are single-pixel lines whose pixel is written out by hand
  typedef struct packed {
    logic                        typed;
    segment_t                    seg;
    logic [lpg_pkg::COORD_W-1:0] px;
    logic [lpg_pkg::COORD_W-1:0] py;
  } line_row_t;

  localparam int NUM_ROWS = 21;
  line_row_t directed_rows [NUM_ROWS] = '{
    // point at the origin, black
    {1'b1, 6'd0,  6'd0,  6'd0,  6'd0,  24'h000000, 6'd0,  6'd0},
    // point at the far corner, white
    {1'b1, 6'd63, 6'd63, 6'd63, 6'd63, 24'hffffff, 6'd63, 6'd63},
    {1'b1, 6'd21, 6'd42, 6'd21, 6'd42, 24'h5a5a5a, 6'd21, 6'd42},
    // full-width horizontal, forward and reversed
    {1'b0, 6'd0,  6'd0,  6'd63, 6'd0,  24'haaaaaa, 6'd0,  6'd0},
    {1'b0, 6'd63, 6'd63, 6'd0,  6'd63, 24'h555555, 6'd0,  6'd0},
    // full-height vertical (steep), forward and reversed
    {1'b0, 6'd0,  6'd0,  6'd0,  6'd63, 24'h0f0f0f, 6'd0,  6'd0},
    {1'b0, 6'd63, 6'd63, 6'd63, 6'd0,  24'hf0f0f0, 6'd0,  6'd0},
    // equal extents stay x-major
    {1'b0, 6'd0,  6'd0,  6'd63, 6'd63, 24'h123456, 6'd0,  6'd0},
    {1'b0, 6'd0,  6'd63, 6'd63, 6'd0,  24'h654321, 6'd0,  6'd0},
    {1'b0, 6'd63, 6'd0,  6'd0,  6'd63, 24'hfedcba, 6'd0,  6'd0},
    {1'b0, 6'd1,  6'd62, 6'd62, 6'd1,  24'h00ff00, 6'd0,  6'd0},
    // accumulator reaches the major extent exactly or just past it
    {1'b0, 6'd0,  6'd0,  6'd2,  6'd1,  24'h800001, 6'd0,  6'd0},
    {1'b0, 6'd0,  6'd0,  6'd4,  6'd2,  24'h7ffffe, 6'd0,  6'd0},
    {1'b0, 6'd0,  6'd0,  6'd63, 6'd1,  24'h0000ff, 6'd0,  6'd0},
    {1'b0, 6'd63, 6'd0,  6'd0,  6'd1,  24'hff0000, 6'd0,  6'd0},
    {1'b0, 6'd0,  6'd0,  6'd63, 6'd32, 24'h333333, 6'd0,  6'd0},
    // steep lines, both directions, minor axis up and down
    {1'b0, 6'd5,  6'd10, 6'd8,  6'd40, 24'hcccccc, 6'd0,  6'd0},
    {1'b0, 6'd8,  6'd40, 6'd5,  6'd10, 24'h999999, 6'd0,  6'd0},
    {1'b0, 6'd0,  6'd63, 6'd1,  6'd0,  24'h111111, 6'd0,  6'd0},
    // shallow with the minor axis counting down, then a one-step diagonal
    {1'b0, 6'd10, 6'd50, 6'd60, 6'd20, 24'heeeeee, 6'd0,  6'd0},
    {1'b0, 6'd30, 6'd30, 6'd31, 6'd31, 24'h777777, 6'd0,  6'd0}
  };

  logic clk;
  logic rst;

  lpg_seg_if seg ();
  lpg_pix_if pix ();

  line_pixel_generator_core u_dut (
    .clk (clk),
    .rst (rst),
    .seg (seg),
    .pix (pix)
  );

  pixel_t pending_pixels [$];
  int     mismatch_count;
  int     idle_cycles;
  bit     calm;
  bit     hold_req;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // walks the segment the way the rasterizer should and queues every pixel
  function automatic void rasterize_segment(input segment_t s);
    int     dx;
    int     dy;
    int     maj0;
    int     min0;
    int     maj1;
    int     min1;
    int     swap;
    int     span;
    int     twice_minor;
    int     err;
    bit     steep;
    bit     up;
    pixel_t p;
    dx = (s.sx > s.ex) ? int'(s.sx) - int'(s.ex) : int'(s.ex) - int'(s.sx);
    dy = (s.sy > s.ey) ? int'(s.sy) - int'(s.ey) : int'(s.ey) - int'(s.sy);
    steep = dy > dx;
    if (steep) begin
      maj0 = int'(s.sy); min0 = int'(s.sx); maj1 = int'(s.ey); min1 = int'(s.ex);
    end else begin
      maj0 = int'(s.sx); min0 = int'(s.sy); maj1 = int'(s.ex); min1 = int'(s.ey);
    end
    if (maj0 > maj1) begin
      swap = maj0; maj0 = maj1; maj1 = swap;
      swap = min0; min0 = min1; min1 = swap;
    end
    up = min1 > min0;
    span = maj1 - maj0;
    twice_minor = 2 * ((min1 > min0) ? min1 - min0 : min0 - min1);
    err = 0;
    for (int n = 0; n < GRID_PIXELS; n++) begin
      p.x     = steep ? min0[lpg_pkg::COORD_W-1:0] : maj0[lpg_pkg::COORD_W-1:0];
      p.y     = steep ? maj0[lpg_pkg::COORD_W-1:0] : min0[lpg_pkg::COORD_W-1:0];
      p.color = s.color;
      p.last  = (maj0 == maj1);
      pending_pixels.push_back(p);
      if (p.last) break;
      err += twice_minor;
      if (err >= span) begin
        min0 = up ? min0 + 1 : min0 - 1;
        err -= 2 * span;
      end
      maj0++;
    end
  endfunction

  // offers one segment beat and returns at the edge where it is taken
  task automatic offer_segment(input segment_t s);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 33) begin
      seg.valid <= 1'b0;
      @(negedge clk);
    end
    seg.valid      <= 1'b1;
    seg.start_x    <= s.sx;
    seg.start_y    <= s.sy;
    seg.end_x      <= s.ex;
    seg.end_y      <= s.ey;
    seg.line_color <= s.color;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
  endtask

  // pixel sink: random backpressure, a long hold-off on request
  initial begin
    pix.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pix.ready <= 1'b0;
        for (int i = 1; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        pix.ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && pix.valid && pix.ready) begin
      got = '{x: pix.pixel_x, y: pix.pixel_y, color: pix.pixel_color, last: pix.last_pixel};
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y));
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x)
          report_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
        if (got.y !== want.y)
          report_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
        if (got.color !== want.color)
          report_mismatch($sformatf("pixel_color %06h, want %06h", got.color, want.color));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_pixel %0b, want %0b at x=%0d y=%0d",
                                    got.last, want.last, want.x, want.y));
      end
    end
  end

  always @(posedge clk) begin
    if ((seg.valid && seg.ready) || (pix.valid && pix.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    segment_t s;
    int       pick;
    rst            = 1'b1;
    seg.valid      = 1'b0;
    seg.start_x    = '0;
    seg.start_y    = '0;
    seg.end_x      = '0;
    seg.end_y      = '0;
    seg.line_color = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_segment(directed_rows[i].seg);
      if (directed_rows[i].typed)
        pending_pixels.push_back('{x: directed_rows[i].px, y: directed_rows[i].py,
                                   color: directed_rows[i].seg.color, last: 1'b1});
      else
        rasterize_segment(directed_rows[i].seg);
    end

    for (int n = 0; n < RANDOM_LINES; n++) begin
      s.sx    = lpg_pkg::COORD_W'($urandom_range(GRID_PIXELS - 1));
      s.sy    = lpg_pkg::COORD_W'($urandom_range(GRID_PIXELS - 1));
      s.color = lpg_pkg::COLOR_W'($urandom);
      pick    = $urandom_range(9);
      if (pick == 0) begin
        s.ex = s.sx;
        s.ey = s.sy;
      end else if (pick < 5) begin
        // short lines keep the run quick and hit many orientations
        s.ex = s.sx ^ lpg_pkg::COORD_W'($urandom_range(7));
        s.ey = s.sy ^ lpg_pkg::COORD_W'($urandom_range(7));
      end else begin
        s.ex = lpg_pkg::COORD_W'($urandom_range(GRID_PIXELS - 1));
        s.ey = lpg_pkg::COORD_W'($urandom_range(GRID_PIXELS - 1));
      end
      if (n == 150) begin
        // sender pauses until the rasterizer has drained
        @(negedge clk);
        seg.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
      end
      offer_segment(s);
      rasterize_segment(s);
      if (n == 60) hold_req = 1'b1;
      calm = (n >= 200 && n < 260);
    end
    @(negedge clk);
    seg.valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
